@@ hw/rtl/nrrcp_pkg.sv @@
// ----------------------------------------------------------------------------
// nrrcp_pkg: shared types and constants of the round-robin NUMA core picker
// Item and result transaction types, opcodes, controller states and the
// command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package nrrcp_pkg;

	localparam int NODE_COUNT_W  = 5;
	localparam int POPULATED_W   = 5;
	localparam int DIVIDEND_W    = 17;
	localparam int STEP_W        = 5;
	localparam int MIN_POPULATED = 2;

	localparam logic OP_ADD  = 1'b0;
	localparam logic OP_PICK = 1'b1;

	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_FAIL = 1'b1;

	typedef struct packed {
		logic        opcode;
		logic [7:0]  core_id;
		logic [3:0]  node_id;
		logic [15:0] worker_index;
		logic [15:0] start_offset;
		logic [15:0] worker_count;
	} item_t;

	typedef struct packed {
		logic       status;
		logic [7:0] chosen_core;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_ADD_WR,
		ST_DIV_NODE,
		ST_READ_CNT,
		ST_PICK_CNT,
		ST_DIV_POS,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic load_item;
		logic add_write;
		logic div_start;
		logic div_sel_cnt;
		logic take_node;
		logic list_read;
		logic res_set;
		logic res_fail;
		logic res_mem;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic is_pick;
		logic add_bad;
		logic pick_bad;
		logic cnt_full;
		logic cnt_zero;
		logic div_done;
		logic out_free;
	} stat_t;

endpackage

@@ hw/rtl/nrrcp_div.sv @@
// ----------------------------------------------------------------------------
// nrrcp_div: iterative restoring divider
// Produces quotient and remainder of a 17-bit dividend, one bit per cycle.
// ----------------------------------------------------------------------------
module nrrcp_div #(
	parameter int DVS_W = 5
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [nrrcp_pkg::DIVIDEND_W-1:0]  dividend,
	input  logic [DVS_W-1:0]                  divisor,
	output logic                              done,
	output logic [nrrcp_pkg::DIVIDEND_W-1:0]  quotient,
	output logic [DVS_W-1:0]                  remainder
);

	logic [nrrcp_pkg::DIVIDEND_W-1:0] dvd_q;
	logic [DVS_W-1:0]                 dvs_q;
	logic [DVS_W-1:0]                 rem_q;
	logic [nrrcp_pkg::STEP_W-1:0]     step_q;
	logic                             busy_q;
	logic                             done_q;
	logic [DVS_W:0]                   trial;
	logic                             fits;

	always_comb begin
		trial = {rem_q, dvd_q[nrrcp_pkg::DIVIDEND_W-1]};
		fits  = trial >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				if (step_q == nrrcp_pkg::STEP_W'(nrrcp_pkg::DIVIDEND_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				step_q <= step_q + nrrcp_pkg::STEP_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[nrrcp_pkg::DIVIDEND_W-2:0], fits};
			rem_q <= fits ? DVS_W'(trial - {1'b0, dvs_q}) : trial[DVS_W-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = dvd_q;
	assign remainder = rem_q;

endmodule

@@ hw/rtl/nrrcp_dp.sv @@
// ----------------------------------------------------------------------------
// nrrcp_dp: datapath of the core picker
// Holds the node register, per-node core counts, core lists, the shared
// divider and the result register.
// ----------------------------------------------------------------------------
module nrrcp_dp #(
	parameter int MAX_NODES          = 16,
	parameter int MAX_CORES_PER_NODE = 256
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	input  logic [nrrcp_pkg::NODE_COUNT_W-1:0]  cfg_data,
	input  nrrcp_pkg::item_t                    item,
	input  logic                                result_stall,
	output logic                                result_valid,
	output nrrcp_pkg::result_t                  result,
	input  nrrcp_pkg::cmd_t                     cmd,
	output nrrcp_pkg::stat_t                    stat
);

	localparam int NODE_W     = $clog2(MAX_NODES);
	localparam int CNT_W      = $clog2(MAX_CORES_PER_NODE + 1);
	localparam int POS_W      = (MAX_CORES_PER_NODE > 1) ? $clog2(MAX_CORES_PER_NODE) : 1;
	localparam int DVS_W      = (CNT_W > nrrcp_pkg::NODE_COUNT_W) ? CNT_W
	                                                              : nrrcp_pkg::NODE_COUNT_W;
	localparam int LIST_DEPTH = MAX_NODES * (2 ** POS_W);

	logic [nrrcp_pkg::NODE_COUNT_W-1:0] node_count_q;
	logic [nrrcp_pkg::POPULATED_W-1:0]  populated_q;
	logic                               opcode_q;
	logic [7:0]                         core_q;
	logic [3:0]                         node_id_q;
	logic [NODE_W-1:0]                  node_q;
	logic [nrrcp_pkg::DIVIDEND_W-1:0]   sum_q;
	logic [nrrcp_pkg::DIVIDEND_W-1:0]   pass_q;
	logic                               wcount_zero_q;

	logic [CNT_W-1:0]                   cnt_mem [MAX_NODES];
	logic [MAX_NODES-1:0]               cnt_vld_q;
	logic [CNT_W-1:0]                   cnt_raw_q;
	logic                               cnt_hit_q;
	logic [CNT_W-1:0]                   cnt;

	logic [7:0]                         list_mem [LIST_DEPTH];
	logic [7:0]                         list_q;

	logic                               res_fail_q;
	logic                               res_mem_q;
	logic                               out_valid_q;
	nrrcp_pkg::result_t                 out_q;

	logic                               div_done;
	logic [nrrcp_pkg::DIVIDEND_W-1:0]   div_quot;
	logic [DVS_W-1:0]                   div_rem;
	logic [nrrcp_pkg::DIVIDEND_W-1:0]   div_dividend;
	logic [DVS_W-1:0]                   div_divisor;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= '0;
		end else if (cfg_valid) begin
			node_count_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			opcode_q      <= item.opcode;
			core_q        <= item.core_id;
			node_id_q     <= item.node_id;
			node_q        <= NODE_W'(item.node_id);
			sum_q         <= {1'b0, item.worker_index} + {1'b0, item.start_offset};
			wcount_zero_q <= item.worker_count == 16'd0;
		end else if (cmd.take_node) begin
			node_q <= NODE_W'(div_rem);
			pass_q <= div_quot;
		end
	end

	always_ff @(posedge clk) begin
		cnt_raw_q <= cnt_mem[node_q];
		if (cmd.add_write) begin
			cnt_mem[node_q] <= cnt + CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_vld_q   <= '0;
			cnt_hit_q   <= 1'b0;
			populated_q <= '0;
		end else begin
			cnt_hit_q <= cnt_vld_q[node_q];
			if (cmd.add_write) begin
				cnt_vld_q[node_q] <= 1'b1;
				if (cnt == '0) begin
					populated_q <= populated_q + nrrcp_pkg::POPULATED_W'(1);
				end
			end
		end
	end

	assign cnt = cnt_hit_q ? cnt_raw_q : '0;

	always_ff @(posedge clk) begin
		if (cmd.add_write) begin
			list_mem[{node_q, POS_W'(cnt)}] <= core_q;
		end
		if (cmd.list_read) begin
			list_q <= list_mem[{node_q, POS_W'(div_rem)}];
		end
	end

	assign div_dividend = cmd.div_sel_cnt ? pass_q : sum_q;
	assign div_divisor  = cmd.div_sel_cnt ? DVS_W'(cnt) : DVS_W'(node_count_q);

	nrrcp_div #(
		.DVS_W(DVS_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quot),
		.remainder(div_rem)
	);

	always_ff @(posedge clk) begin
		if (cmd.res_set) begin
			res_fail_q <= cmd.res_fail;
			res_mem_q  <= cmd.res_mem;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q.status      <= res_fail_q ? nrrcp_pkg::STATUS_FAIL : nrrcp_pkg::STATUS_OK;
			out_q.chosen_core <= (!res_fail_q && res_mem_q) ? list_q : 8'd0;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

	always_comb begin
		stat.is_pick  = opcode_q == nrrcp_pkg::OP_PICK;
		stat.add_bad  = ({1'b0, node_id_q} >= node_count_q) ||
		                (32'(node_id_q) >= 32'(MAX_NODES));
		stat.pick_bad = wcount_zero_q ||
		                (32'(node_count_q) < 32'(nrrcp_pkg::MIN_POPULATED)) ||
		                (32'(node_count_q) > 32'(MAX_NODES)) ||
		                (32'(populated_q) < 32'(nrrcp_pkg::MIN_POPULATED));
		stat.cnt_full = 32'(cnt) >= 32'(MAX_CORES_PER_NODE);
		stat.cnt_zero = cnt == '0;
		stat.div_done = div_done;
		stat.out_free = !out_valid_q || !result_stall;
	end

endmodule

@@ hw/rtl/nrrcp_ctrl.sv @@
// ----------------------------------------------------------------------------
// nrrcp_ctrl: controller of the core picker
// Steps one item through decode, table update or the two divisions of a
// pick, and hands the result to the output register.
// ----------------------------------------------------------------------------
module nrrcp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  nrrcp_pkg::stat_t  stat,
	output nrrcp_pkg::cmd_t   cmd
);

	nrrcp_pkg::state_t state_q;
	nrrcp_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= nrrcp_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			nrrcp_pkg::ST_IDLE: begin
				if (item_valid) state_d = nrrcp_pkg::ST_DECODE;
			end
			nrrcp_pkg::ST_DECODE: begin
				if (stat.is_pick) begin
					state_d = stat.pick_bad ? nrrcp_pkg::ST_FINISH : nrrcp_pkg::ST_DIV_NODE;
				end else begin
					state_d = stat.add_bad ? nrrcp_pkg::ST_FINISH : nrrcp_pkg::ST_ADD_WR;
				end
			end
			nrrcp_pkg::ST_ADD_WR: state_d = nrrcp_pkg::ST_FINISH;
			nrrcp_pkg::ST_DIV_NODE: begin
				if (stat.div_done) state_d = nrrcp_pkg::ST_READ_CNT;
			end
			nrrcp_pkg::ST_READ_CNT: state_d = nrrcp_pkg::ST_PICK_CNT;
			nrrcp_pkg::ST_PICK_CNT: begin
				state_d = stat.cnt_zero ? nrrcp_pkg::ST_FINISH : nrrcp_pkg::ST_DIV_POS;
			end
			nrrcp_pkg::ST_DIV_POS: begin
				if (stat.div_done) state_d = nrrcp_pkg::ST_FINISH;
			end
			nrrcp_pkg::ST_FINISH: begin
				if (stat.out_free) state_d = nrrcp_pkg::ST_IDLE;
			end
			default: state_d = nrrcp_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd        = '0;
		item_stall = 1'b1;
		case (state_q)
			nrrcp_pkg::ST_IDLE: begin
				item_stall    = 1'b0;
				cmd.load_item = item_valid;
			end
			nrrcp_pkg::ST_DECODE: begin
				if (stat.is_pick) begin
					if (stat.pick_bad) begin
						cmd.res_set  = 1'b1;
						cmd.res_fail = 1'b1;
					end else begin
						cmd.div_start = 1'b1;
					end
				end else if (stat.add_bad) begin
					cmd.res_set  = 1'b1;
					cmd.res_fail = 1'b1;
				end
			end
			nrrcp_pkg::ST_ADD_WR: begin
				cmd.res_set   = 1'b1;
				cmd.res_fail  = stat.cnt_full;
				cmd.add_write = !stat.cnt_full;
			end
			nrrcp_pkg::ST_DIV_NODE: begin
				cmd.take_node = stat.div_done;
			end
			nrrcp_pkg::ST_READ_CNT: begin
				cmd = '0;
			end
			nrrcp_pkg::ST_PICK_CNT: begin
				cmd.div_sel_cnt = 1'b1;
				if (stat.cnt_zero) begin
					cmd.res_set  = 1'b1;
					cmd.res_fail = 1'b1;
				end else begin
					cmd.div_start = 1'b1;
				end
			end
			nrrcp_pkg::ST_DIV_POS: begin
				if (stat.div_done) begin
					cmd.list_read = 1'b1;
					cmd.res_set   = 1'b1;
					cmd.res_mem   = 1'b1;
				end
			end
			nrrcp_pkg::ST_FINISH: begin
				cmd.out_load = stat.out_free;
			end
			default: begin
				cmd        = '0;
				item_stall = 1'b1;
			end
		endcase
	end

endmodule

@@ hw/rtl/numa_round_robin_core_picker_top.sv @@
// ----------------------------------------------------------------------------
// numa_round_robin_core_picker_top: round-robin NUMA core picker
// Keeps a per-node core table and places workers on nodes round-robin.
// ----------------------------------------------------------------------------
// The block works on one item at a time. It accepts the next item in the
// cycle after the result of the previous one has been loaded into the
// output register. An add transaction passes through decode and the table
// write, and skips the write when its node is out of range. During a pick
// the shared 17-step restoring divider runs twice, once to split the
// worker's position into node and pass, and once to reduce the pass modulo
// the node's core count. Between the runs the count is looked up in the
// read-count and pick-count states, and a list read follows the second run.
// A pick that fails its checks goes from decode straight to the finish
// state, and a pick that lands on an empty node skips the second run. A
// finished result waits in the output register while the next item is
// accepted. If the previous result is still stalled there, the new result
// waits in the datapath and the input stays stalled. The core lists live in
// a memory without reset. The core counts reset through per-node valid
// bits, so no clearing pass is needed after reset.
module numa_round_robin_core_picker_top #(
	parameter int MAX_NODES          = 16,
	parameter int MAX_CORES_PER_NODE = 256
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [nrrcp_pkg::NODE_COUNT_W-1:0]  cfg_data,
	input  logic                                item_valid,
	output logic                                item_stall,
	input  nrrcp_pkg::item_t                    item,
	output logic                                result_valid,
	input  logic                                result_stall,
	output nrrcp_pkg::result_t                  result
);

	nrrcp_pkg::cmd_t  cmd;
	nrrcp_pkg::stat_t stat;

	assign cfg_ready = 1'b1;

	nrrcp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	nrrcp_dp #(
		.MAX_NODES         (MAX_NODES),
		.MAX_CORES_PER_NODE(MAX_CORES_PER_NODE)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_data    (cfg_data),
		.item        (item),
		.result_stall(result_stall),
		.result_valid(result_valid),
		.result      (result),
		.cmd         (cmd),
		.stat        (stat)
	);

endmodule

@@ hw/rtl/nrrcp_checker.sv @@
// ----------------------------------------------------------------------------
// nrrcp_checker: port-level checks of the core picker
// Watches the item and result ports over time.
// ----------------------------------------------------------------------------
module nrrcp_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                item_valid,
	input logic                                item_stall,
	input logic                                result_valid,
	input logic                                result_stall,
	input nrrcp_pkg::result_t                  result
);

	// A stalled result transaction must stay offered.
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result dropped while stalled");

	// A stalled result transaction must not change.
	a_result_stable: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(result))
		else $error("result changed while stalled");

	// A failed transaction never reports a core.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.status == nrrcp_pkg::STATUS_FAIL |->
		result.chosen_core == 8'd0)
		else $error("failed result carries a core");

	// One item is worked on at a time, so an accepted item blocks the next.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> item_stall)
		else $error("item accepted while busy");

endmodule

bind numa_round_robin_core_picker_top nrrcp_checker u_nrrcp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.item_valid  (item_valid),
	.item_stall  (item_stall),
	.result_valid(result_valid),
	.result_stall(result_stall),
	.result      (result)
);
